>>> design/sqm_pkg.sv
package sqm_pkg;

  // Fraction bits of the normalised move time t
  localparam int unsigned TIME_FRAC_BITS = 16;

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ANGLE_W  = 15;
  localparam int unsigned RUN_W    = 16;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PULSE_W  = 15;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 15'd18000;
  localparam logic [PULSE_W-1:0] PULSE_BASE = 15'd500;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2500;

  // angle / 9 as (angle * 7282) >> 16, exact for angles up to the range limit
  localparam int unsigned RECIP9_W  = 13;
  localparam logic [RECIP9_W-1:0] RECIP9 = 13'd7282;
  localparam int unsigned RECIP9_SH = 16;
  localparam int unsigned QUOT_W    = 11;

  // Polynomial accumulator holds values below 16 * 2^F
  localparam int unsigned POLY_W = TIME_FRAC_BITS + 4;
  localparam logic [POLY_W-1:0] TIME_ONE = POLY_W'(1) << TIME_FRAC_BITS;
  localparam logic [POLY_W-1:0] TEN_ONE  = POLY_W'(10) << TIME_FRAC_BITS;

  // Shared multiplier operand widths
  localparam int unsigned MUL_A_W = (POLY_W > ANGLE_W) ? POLY_W : ANGLE_W;
  localparam int unsigned MUL_B_W =
      (TIME_FRAC_BITS + 1 > RECIP9_W) ? TIME_FRAC_BITS + 1 : RECIP9_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Division step counter
  localparam int unsigned CNT_W = $clog2(TIME_FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_JUMP = 2'd2
  } action_e;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_DIV      = 10'b00_0000_0010,
    ST_SQ       = 10'b00_0000_0100,
    ST_POLY     = 10'b00_0000_1000,
    ST_CUBE     = 10'b00_0001_0000,
    ST_CUBE_TK  = 10'b00_0010_0000,
    ST_SCALE    = 10'b00_0100_0000,
    ST_SCALE_TK = 10'b00_1000_0000,
    ST_PULSE    = 10'b01_0000_0000,
    ST_PULSE_TK = 10'b10_0000_0000
  } seq_state_e;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_lo;
    logic [PULSE_W-1:0] pulse_hi;
  } sqm_cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ANGLE_W-1:0]  angle;
    logic [RUN_W-1:0]    run_time_ms;
    logic [NOW_W-1:0]    now_ms;
  } sqm_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic [ANGLE_W-1:0] out_angle;
    logic               move_done;
  } sqm_res_t;

endpackage

>>> design/sqm_mul.sv
module sqm_mul import sqm_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] op_a_i,
  input  logic [MUL_B_W-1:0] op_b_i,
  output logic [PROD_W-1:0]  prod_o
);

  logic [PROD_W-1:0] prod_q;

  // Register every product; the sequencer reads it in the cycle after issue
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> design/sqm_seq.sv
module sqm_seq import sqm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sqm_cfg_t           cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  sqm_item_t          item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output sqm_res_t           res_o,
  output logic [MUL_A_W-1:0] op_a_o,
  output logic [MUL_B_W-1:0] op_b_o,
  input  logic [PROD_W-1:0]  prod_i
);

  seq_state_e state_q, state_d;

  logic [ANGLE_W-1:0] start_q, start_d;
  logic [ANGLE_W-1:0] goal_q, goal_d;
  logic [ANGLE_W-1:0] present_q, present_d;
  logic [NOW_W-1:0]   mstart_q, mstart_d;
  logic [RUN_W-1:0]   dur_q, dur_d;
  logic               moving_q, moving_d;
  logic               done_q, done_d;

  logic [RUN_W-1:0]          rem_q, rem_d;
  logic [TIME_FRAC_BITS-1:0] t_q, t_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [POLY_W-1:0]         a_q, a_d;

  logic     out_valid_q, out_valid_d;
  sqm_res_t out_q, out_d;

  logic               accept;
  logic [ANGLE_W-1:0] ang_sat;
  logic [NOW_W-1:0]   elapsed;
  logic               move_end;
  logic [RUN_W:0]     rem_sh;
  logic               rem_ge;
  logic               goal_ge;
  logic [ANGLE_W-1:0] diff;
  logic [TIME_FRAC_BITS:0] s_cap;
  logic [2*TIME_FRAC_BITS-1:0] t_sq;
  logic [2*TIME_FRAC_BITS+2:0] six_sq;
  logic [POLY_W-1:0]  pos, neg;
  logic [ANGLE_W-1:0] delta;
  logic [ANGLE_W:0]   up_sum;
  logic [QUOT_W-1:0]  quot;
  logic [PULSE_W-1:0] pw_raw, pw_hi, pw;

  assign accept       = item_valid_i && item_ready_o;
  assign item_ready_o = (state_q == ST_IDLE);
  assign ang_sat      = (item_i.angle > ANGLE_MAX) ? ANGLE_MAX : item_i.angle;
  assign elapsed      = item_i.now_ms - mstart_q;
  assign move_end     = (dur_q == '0) || (elapsed >= NOW_W'(dur_q));

  // Restoring division step: remainder always stays below the run time
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, dur_q};

  assign goal_ge = goal_q >= start_q;
  assign diff    = goal_ge ? goal_q - start_q : start_q - goal_q;
  assign s_cap   = (a_q > TIME_ONE) ? TIME_ONE[TIME_FRAC_BITS:0] : a_q[TIME_FRAC_BITS:0];

  // a = floor(6 t^2 / 2^F) + 10 - 15 t, floored at zero
  assign t_sq   = prod_i[2*TIME_FRAC_BITS-1:0];
  assign six_sq = ({3'b000, t_sq} << 2) + ({3'b000, t_sq} << 1);
  assign pos    = POLY_W'(six_sq >> TIME_FRAC_BITS) + TEN_ONE;
  assign neg    = (POLY_W'(t_q) << 4) - POLY_W'(t_q);

  assign delta  = prod_i[TIME_FRAC_BITS +: ANGLE_W];
  assign up_sum = {1'b0, start_q} + {1'b0, delta};

  assign quot   = prod_i[RECIP9_SH +: QUOT_W];
  assign pw_raw = PULSE_BASE + PULSE_W'(quot);
  assign pw_hi  = (pw_raw > cfg_i.pulse_hi) ? cfg_i.pulse_hi : pw_raw;
  assign pw     = (pw_hi < cfg_i.pulse_lo) ? cfg_i.pulse_lo : pw_hi;

  // Operand select for the shared multiplier
  always_comb begin
    op_a_o = '0;
    op_b_o = '0;
    unique case (state_q)
      ST_SQ: begin
        op_a_o = MUL_A_W'(t_q);
        op_b_o = MUL_B_W'(t_q);
      end
      ST_CUBE: begin
        op_a_o = MUL_A_W'(a_q);
        op_b_o = MUL_B_W'(t_q);
      end
      ST_SCALE: begin
        op_a_o = MUL_A_W'(diff);
        op_b_o = MUL_B_W'(s_cap);
      end
      // Keep the pulse operands while the result waits for the output register
      ST_PULSE, ST_PULSE_TK: begin
        op_a_o = MUL_A_W'(present_q);
        op_b_o = MUL_B_W'(RECIP9);
      end
      default: begin
        op_a_o = '0;
        op_b_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    goal_d      = goal_q;
    present_d   = present_q;
    mstart_d    = mstart_q;
    dur_d       = dur_q;
    moving_d    = moving_q;
    done_d      = done_q;
    rem_d       = rem_q;
    t_d         = t_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_i.action)
            ACT_JUMP: begin
              start_d   = ang_sat;
              goal_d    = ang_sat;
              present_d = ang_sat;
              moving_d  = 1'b0;
              done_d    = 1'b1;
              state_d   = ST_PULSE;
            end
            ACT_MOVE: begin
              goal_d   = ang_sat;
              dur_d    = item_i.run_time_ms;
              mstart_d = item_i.now_ms;
              start_d  = present_q;
              moving_d = 1'b1;
            end
            ACT_TICK: begin
              if (moving_q) begin
                if (move_end) begin
                  present_d = goal_q;
                  start_d   = goal_q;
                  moving_d  = 1'b0;
                  done_d    = 1'b1;
                  state_d   = ST_PULSE;
                end else begin
                  // elapsed is below the run time here, so it fits RUN_W bits
                  rem_d   = elapsed[RUN_W-1:0];
                  t_d     = '0;
                  cnt_d   = '0;
                  done_d  = 1'b0;
                  state_d = ST_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? RUN_W'(rem_sh - {1'b0, dur_q}) : rem_sh[RUN_W-1:0];
        t_d   = {t_q[TIME_FRAC_BITS-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TIME_FRAC_BITS - 1)) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        state_d = ST_POLY;
      end
      ST_POLY: begin
        a_d     = (pos > neg) ? pos - neg : '0;
        cnt_d   = '0;
        state_d = ST_CUBE;
      end
      ST_CUBE: begin
        state_d = ST_CUBE_TK;
      end
      ST_CUBE_TK: begin
        a_d   = prod_i[TIME_FRAC_BITS +: POLY_W];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(2)) begin
          state_d = ST_SCALE;
        end else begin
          state_d = ST_CUBE;
        end
      end
      ST_SCALE: begin
        state_d = ST_SCALE_TK;
      end
      ST_SCALE_TK: begin
        if (goal_ge) begin
          present_d = (up_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : up_sum[ANGLE_W-1:0];
        end else begin
          present_d = (delta > start_q) ? '0 : start_q - delta;
        end
        state_d = ST_PULSE;
      end
      ST_PULSE: begin
        state_d = ST_PULSE_TK;
      end
      ST_PULSE_TK: begin
        // Hold until the output register is free
        if (!out_valid_q || res_ready_i) begin
          out_d.pulse_width = pw;
          out_d.out_angle   = present_q;
          out_d.move_done   = done_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      goal_q      <= '0;
      present_q   <= '0;
      mstart_q    <= '0;
      dur_q       <= '0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      goal_q      <= goal_d;
      present_q   <= present_d;
      mstart_q    <= mstart_d;
      dur_q       <= dur_d;
      moving_q    <= moving_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    rem_q  <= rem_d;
    t_q    <= t_d;
    cnt_q  <= cnt_d;
    a_q    <= a_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < dur_q))
    else $error("division remainder reached the run time");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (present_q <= ANGLE_MAX) && (goal_q <= ANGLE_MAX) && (start_q <= ANGLE_MAX))
    else $error("angle state left its range");

  a_jump_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.action == ACT_JUMP)) |=> (!moving_q && (state_q == ST_PULSE)))
    else $error("jump did not stop the move");

  a_profile_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_SCALE_TK) |-> moving_q)
    else $error("profile evaluated while not moving");

  a_result_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PULSE) |=> (state_q == ST_PULSE_TK))
    else $error("pulse product not taken");

endmodule

>>> design/servo_quintic_motion_profile_top.sv
// Channel   Direction  Transfer when                    Contents
// s_axis    in         s_axis_tvalid & s_axis_tready    action, angle, run time, time stamp
// m_axis    out        m_axis_tvalid & m_axis_tready    pulse width, angle, end of move
// cfg       in         cfg_valid_i & cfg_ready_o        pulse limit register writes
//
// A tick during a move runs 16 restoring division steps for t, then six passes through
// the shared multiplier (t^2, three Horner products, angle scale, pulse scale), each
// issued to the multiplier and taken from its product register. A jump, or a tick
// that ends a move, goes straight to ST_PULSE and ST_PULSE_TK. A move or an ignored
// item leaves the sequencer idle. The input is ready only in the idle state.
// A result waits in the output register; the next item is taken meanwhile, and only
// its own result stalls behind a full output register. Reset clears all profile state.
module servo_quintic_motion_profile_top import sqm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [14:0] angle, [30:15] run_time_ms, [62:31] now_ms, [63] zero
  input  logic [63:0]          s_axis_tdata,
  // [1:0] action
  input  logic [ACTION_W-1:0]  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [14:0] pulse width, [29:15] profiled angle, [31:30] zero
  output logic [31:0]          m_axis_tdata,
  // move_done
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PULSE_W-1:0]   cfg_data_i
);

  sqm_cfg_t  cfg_q;
  sqm_item_t item;
  sqm_res_t  res;

  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [PROD_W-1:0]  prod;

  // Writes must come only while idle; the block does not enforce this and takes them at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_lo <= MIN_PULSE_RST;
      cfg_q.pulse_hi <= MAX_PULSE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Drop writes to indexes beyond the register list
      unique case (cfg_index_i)
        CFG_MIN_PULSE: cfg_q.pulse_lo <= cfg_data_i;
        CFG_MAX_PULSE: cfg_q.pulse_hi <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input item
  assign item.action      = s_axis_tuser;
  assign item.angle       = s_axis_tdata[14:0];
  assign item.run_time_ms = s_axis_tdata[30:15];
  assign item.now_ms      = s_axis_tdata[62:31];

  sqm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res),
    .op_a_o       (op_a),
    .op_b_o       (op_b),
    .prod_i       (prod)
  );

  sqm_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Pack the result
  assign m_axis_tdata = {2'b00, res.out_angle, res.pulse_width};
  assign m_axis_tlast = res.move_done;

endmodule

>>> dv/tb.sv
module tb;
  import sqm_pkg::*;

  localparam int unsigned CENTIDEG_PER_US = 9;
  // Action code with no meaning: the block must drop it silently
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  // Register indexes outside the map: writes must leave the limits alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  // Allow a tick during a move time to finish, with margin, before touching registers
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned HOLD_AFTER_RESULTS = 40;

  typedef struct {
    sqm_item_t it;
    bit        typed;
    bit        yields;
    sqm_res_t  want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;
  logic [ACTION_W-1:0]  s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [PULSE_W-1:0]   cfg_data_i = '0;

  // Own copy of the profile state and the pulse limits
  logic [ANGLE_W-1:0] prof_start, prof_goal, prof_present;
  logic [NOW_W-1:0]   prof_t0;
  logic [RUN_W-1:0]   prof_run;
  bit                 prof_moving;
  logic [PULSE_W-1:0] lim_min, lim_max;

  sqm_res_t  pending_pulses[$];
  stim_row_t directed_rows[$];
  sqm_res_t  head;
  int        failures = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        settings_used = 1;
  int        burst_left = 0;
  bit        steady = 1'b0;
  logic [31:0] clock_ms = 32'd20000;

  servo_quintic_motion_profile_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Advance the profile by one item; return 1 when the item yields a pulse
  function automatic bit advance_profile(input sqm_item_t it, output sqm_res_t res);
    logic [ANGLE_W-1:0] ang;
    logic [31:0]        elapsed;
    logic [63:0]        t, a, s, d, sum;
    logic [31:0]        p;
    bit                 done;
    ang = (it.angle > ANGLE_MAX) ? ANGLE_MAX : it.angle;
    done = 1'b0;
    res = '0;
    case (it.action)
      ACT_JUMP: begin
        prof_start = ang;
        prof_goal = ang;
        prof_present = ang;
        prof_moving = 1'b0;
        done = 1'b1;
      end
      ACT_MOVE: begin
        prof_goal = ang;
        prof_run = it.run_time_ms;
        prof_t0 = it.now_ms;
        prof_start = prof_present;
        prof_moving = 1'b1;
        return 1'b0;
      end
      ACT_TICK: begin
        if (!prof_moving) return 1'b0;
        elapsed = it.now_ms - prof_t0;
        if (prof_run == '0 || elapsed >= 32'(prof_run)) begin
          // move finished: land exactly on the goal
          prof_present = prof_goal;
          prof_start = prof_goal;
          prof_moving = 1'b0;
          done = 1'b1;
        end else begin
          t = (64'(elapsed) << TIME_FRAC_BITS) / 64'(prof_run);
          // Horner form of 6t^5 - 15t^4 + 10t^3, floored at each step
          a = ((64'd6 * t * t) >> TIME_FRAC_BITS) + (64'd10 << TIME_FRAC_BITS);
          a = (a > 64'd15 * t) ? a - 64'd15 * t : 64'd0;
          repeat (3) a = (a * t) >> TIME_FRAC_BITS;
          s = (a > (64'd1 << TIME_FRAC_BITS)) ? (64'd1 << TIME_FRAC_BITS) : a;
          if (prof_goal >= prof_start) begin
            d = ((64'(prof_goal) - 64'(prof_start)) * s) >> TIME_FRAC_BITS;
            sum = 64'(prof_start) + d;
            prof_present = (sum > 64'(ANGLE_MAX)) ? ANGLE_MAX : sum[ANGLE_W-1:0];
          end else begin
            d = ((64'(prof_start) - 64'(prof_goal)) * s) >> TIME_FRAC_BITS;
            prof_present = (d > 64'(prof_start)) ? '0 : ANGLE_W'(64'(prof_start) - d);
          end
        end
      end
      default: return 1'b0;
    endcase
    p = 32'(PULSE_BASE) + 32'(prof_present) / CENTIDEG_PER_US;
    if (p > 32'(lim_max)) p = 32'(lim_max);
    if (p < 32'(lim_min)) p = 32'(lim_min);
    res.pulse_width = p[PULSE_W-1:0];
    res.out_angle = prof_present;
    res.move_done = done;
    return 1'b1;
  endfunction

  // Offer one item in bursts with random gaps; predict it once transferred.
  // A typed row supplies its own expectation in place of the prediction.
  task automatic offer(input sqm_item_t it, input bit typed = 1'b0,
                       input bit want_yield = 1'b0, input sqm_res_t want = '0);
    int       gap;
    sqm_res_t pred;
    bit       yields;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.now_ms, it.run_time_ms, it.angle};
    s_axis_tuser  <= it.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    yields = advance_profile(it, pred);
    if (typed) begin
      if (want_yield) pending_pulses.push_back(want);
    end else if (yields) begin
      pending_pulses.push_back(pred);
    end
  endtask

  // Drop valid, drain every expected pulse, then let in-flight moves settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi,
                              input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx[$];
    logic [PULSE_W-1:0]   val[$];
    if (poke_spare) begin
      idx.push_back(CFG_SPARE_LO);
      val.push_back(15'h7FFF);
      idx.push_back(CFG_SPARE_HI);
      val.push_back(15'h2AAA);
    end
    idx.push_back(CFG_MIN_PULSE);
    val.push_back(lo);
    idx.push_back(CFG_MAX_PULSE);
    val.push_back(hi);
    foreach (idx[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    lim_min = lo;
    lim_max = hi;
    settings_used++;
  endtask

  task automatic add_row(input logic [ACTION_W-1:0] act, input int unsigned ang,
                         input int unsigned run, input logic [31:0] now, input bit typed,
                         input bit yields, input int unsigned pulse, input int unsigned angle,
                         input bit done);
    stim_row_t r;
    r.it.action = act;
    r.it.angle = ANGLE_W'(ang);
    r.it.run_time_ms = RUN_W'(run);
    r.it.now_ms = now;
    r.typed = typed;
    r.yields = yields;
    r.want.pulse_width = PULSE_W'(pulse);
    r.want.out_angle = ANGLE_W'(angle);
    r.want.move_done = done;
    directed_rows.push_back(r);
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return ANGLE_W'($urandom_range(0, 32767));
      1: return ($urandom_range(0, 1) != 0) ? ANGLE_MAX : '0;
      default: return ANGLE_W'($urandom_range(0, 18000));
    endcase
  endfunction

  function automatic logic [RUN_W-1:0] pick_run();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return 16'hFFFF;
      2, 3: return RUN_W'($urandom_range(0, 65535));
      default: return RUN_W'($urandom_range(1, 400));
    endcase
  endfunction

  // Mostly moves followed by ticks through the profile; some jumps, stray ticks,
  // spare action codes and time stamp jumps as noise. Spare codes do not count.
  task automatic random_phase(input int quota);
    int          counted;
    int          nticks;
    int unsigned run;
    sqm_item_t   it;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          it.action = ACT_MOVE;
          it.angle = pick_angle();
          it.run_time_ms = pick_run();
          it.now_ms = clock_ms;
          run = it.run_time_ms;
          offer(it);
          counted++;
          nticks = $urandom_range(1, 8);
          for (int i = 0; i < nticks; i++) begin
            clock_ms += $urandom_range(0, run / 3 + 1);
            // often push the last tick past the run time to finish the move
            if (i == nticks - 1 && $urandom_range(0, 2) != 0)
              clock_ms += run + $urandom_range(0, 3);
            it.action = ACT_TICK;
            it.angle = ANGLE_W'($urandom_range(0, 32767));
            it.run_time_ms = RUN_W'($urandom_range(0, 65535));
            it.now_ms = clock_ms;
            offer(it);
            counted++;
          end
        end
        11, 12: begin
          it.action = ACT_JUMP;
          it.angle = pick_angle();
          it.run_time_ms = RUN_W'($urandom_range(0, 65535));
          it.now_ms = $urandom;
          offer(it);
          counted++;
        end
        13: begin
          it.action = ACT_TICK;
          it.angle = ANGLE_W'($urandom_range(0, 32767));
          it.run_time_ms = RUN_W'($urandom_range(0, 65535));
          it.now_ms = ($urandom_range(0, 1) != 0) ? 32'($urandom) : clock_ms;
          offer(it);
          counted++;
        end
        14: begin
          it.action = ACT_SPARE;
          it.angle = ANGLE_W'($urandom_range(0, 32767));
          it.run_time_ms = RUN_W'($urandom_range(0, 65535));
          it.now_ms = $urandom;
          offer(it);
        end
        default: begin
          // jump the clock: near the wrap point or anywhere
          clock_ms = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                                 : 32'($urandom);
        end
      endcase
    end
  endtask

  // Result checker: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_pulses.size() == 0) begin
        $error("result with nothing expected: pulse_width %0d out_angle %0d move_done %0d",
               m_axis_tdata[PULSE_W-1:0], m_axis_tdata[PULSE_W+ANGLE_W-1:PULSE_W],
               m_axis_tlast);
        failures++;
      end else begin
        head = pending_pulses.pop_front();
        if (m_axis_tdata[PULSE_W-1:0] !== head.pulse_width) begin
          $error("pulse_width: expected %0d, got %0d", head.pulse_width,
                 m_axis_tdata[PULSE_W-1:0]);
          failures++;
        end
        if (m_axis_tdata[PULSE_W+ANGLE_W-1:PULSE_W] !== head.out_angle) begin
          $error("out_angle: expected %0d, got %0d", head.out_angle,
                 m_axis_tdata[PULSE_W+ANGLE_W-1:PULSE_W]);
          failures++;
        end
        if (m_axis_tlast !== head.move_done) begin
          $error("move_done: expected %0d, got %0d", head.move_done, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  // Receiver: stall on a pattern that changes now and then; once, hold off for a
  // long stretch so that the output register fills and the input stalls behind it
  initial begin : receiver
    int mode;
    bit held;
    mode = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= HOLD_AFTER_RESULTS) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    prof_start = '0;
    prof_goal = '0;
    prof_present = '0;
    prof_t0 = '0;
    prof_run = '0;
    prof_moving = 1'b0;
    lim_min = MIN_PULSE_RST;
    lim_max = MAX_PULSE_RST;

    // Directed rows run on the reset limits (500 to 2500 us)
    add_row(ACT_TICK,  0,     0,     32'd0,         1, 0, 0,    0,     0); // idle after reset
    add_row(ACT_JUMP,  0,     0,     32'd0,         1, 1, 500,  0,     1);
    add_row(ACT_JUMP,  18000, 0,     32'd0,         1, 1, 2500, 18000, 1);
    add_row(ACT_JUMP,  32767, 0,     32'd0,         1, 1, 2500, 18000, 1); // saturate
    add_row(ACT_SPARE, 9000,  65535, 32'hFFFF_FFFF, 1, 0, 0,    0,     0);
    add_row(ACT_MOVE,  0,     100,   32'd1000,      1, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'd1000,      1, 1, 2500, 18000, 0); // t is zero
    add_row(ACT_TICK,  0,     0,     32'd1050,      0, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'd1099,      0, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'd1100,      1, 1, 500,  0,     1); // lands on goal
    add_row(ACT_MOVE,  18000, 0,     32'd5,         1, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'd5,         1, 1, 2500, 18000, 1); // zero run time
    add_row(ACT_MOVE,  9000,  65535, 32'hFFFF_FFF0, 1, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'h0000_0010, 0, 0, 0,    0,     0); // wrapped clock
    add_row(ACT_MOVE,  0,     1000,  32'd100,       1, 0, 0,    0,     0); // restart mid-move
    add_row(ACT_TICK,  32767, 65535, 32'd600,       0, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'hFFFF_FFFF, 1, 1, 500,  0,     1);
    add_row(ACT_TICK,  0,     0,     32'd5,         1, 0, 0,    0,     0); // idle again
    add_row(ACT_JUMP,  9,     0,     32'd0,         1, 1, 501,  9,     1);
    add_row(ACT_MOVE,  32767, 1,     32'd7,         1, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'd7,         1, 1, 501,  9,     0);
    add_row(ACT_TICK,  0,     0,     32'd8,         1, 1, 2500, 18000, 1);
    add_row(ACT_JUMP,  8999,  0,     32'd0,         1, 1, 1499, 8999,  1);
    add_row(ACT_MOVE,  17999, 2,     32'd0,         1, 0, 0,    0,     0);
    add_row(ACT_TICK,  0,     0,     32'd1,         0, 0, 0,    0,     0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].yields,
            directed_rows[i].want);

    // Random phases, each under its own pulse limits, extremes first
    for (int k = 0; k < 5; k++) begin
      wait_idle();
      case (k)
        0: write_limits(15'd0, 15'h7FFF, 1'b1);
        1: write_limits(15'd20000, 15'd0, 1'b0); // crossed limits
        2: write_limits(15'd1000, 15'd1800, 1'b0);
        3: write_limits(15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000)), 1'b0);
        default: write_limits(15'($urandom_range(0, 700)), 15'($urandom_range(2000, 20000)),
                              1'b0);
      endcase
      random_phase(106);
    end

    wait_idle();
    $display("Covered %0d input transfers and %0d checked results over %0d pulse limit settings,",
             items_sent, results_seen, settings_used);
    $display("with jumps, moves, restarts, wrapped time stamps, zero run times and crossed limits.");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
